@@ rtl/core/htb_pkg.sv @@
// Shared types and constants for the tree build codec core.
`default_nettype none
package htb_pkg;
    localparam int MAX_LEAVES_DEF  = 32;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int CODE_W          = 63;
    localparam int LEN_W           = 6;
    localparam int SYM_W           = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_MERGE,
        ST_EMIT_INIT,
        ST_EMIT_RD,
        ST_EMIT_STEP,
        ST_EMIT_OUT,
        ST_DEC_RD,
        ST_DEC_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store a leaf
        logic scan_init;   // start a minimum search
        logic scan_step;   // examine one node
        logic merge;       // write merged node
        logic emit_init;   // start code walk for current leaf
        logic emit_rd;     // read parent of current node
        logic emit_step;   // climb one level
        logic emit_out;    // present code entry
        logic emit_next;   // advance to next leaf
        logic build_done;  // mark tree ready
        logic dec_rd;      // read child of walk node
        logic dec_out;     // finish decode step
    } htb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_leaves;  // leaf count nonzero after this load
        logic scan_end;    // last node of search examined
        logic merges_done; // no merge left
        logic at_root;     // current node has no parent, or the code length has reached 63
        logic leaves_done; // last leaf emitted
        logic dec_ok;      // decode may run
    } htb_sts_t;
endpackage
`default_nettype wire

@@ rtl/core/htb_ctrl.sv @@
// Controller state machine for the tree build codec core.
`default_nettype none
module htb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             cmd,
    input  wire logic             last_leaf,
    input  wire htb_pkg::htb_sts_t sts,
    output htb_pkg::htb_cmd_t     ctl,
    output logic                  busy
);
    htb_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= htb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        busy = 1'b1;
        unique case (state_reg)
            htb_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (!cmd)
                    begin
                        ctl.load = 1'b1;
                        if (last_leaf && sts.has_leaves)
                        begin
                            ctl.scan_init = 1'b1;
                            state_next = htb_pkg::ST_SCAN;
                        end
                    end
                    else if (sts.dec_ok)
                    begin
                        ctl.dec_rd = 1'b1;
                        state_next = htb_pkg::ST_DEC_RD;
                    end
                end
            end
            htb_pkg::ST_SCAN:
            begin
                if (sts.merges_done)
                begin
                    ctl.emit_init = 1'b1;
                    state_next = htb_pkg::ST_EMIT_RD;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                    if (sts.scan_end)
                        state_next = htb_pkg::ST_SCAN_WAIT;
                end
            end
            // The compare of the last node read finishes in this cycle.
            htb_pkg::ST_SCAN_WAIT:
            begin
                state_next = htb_pkg::ST_MERGE;
            end
            htb_pkg::ST_MERGE:
            begin
                ctl.merge = 1'b1;
                ctl.scan_init = 1'b1;
                state_next = htb_pkg::ST_SCAN;
            end
            htb_pkg::ST_EMIT_INIT:
            begin
                ctl.emit_init = 1'b1;
                state_next = htb_pkg::ST_EMIT_RD;
            end
            htb_pkg::ST_EMIT_RD:
            begin
                if (sts.at_root)
                begin
                    state_next = htb_pkg::ST_EMIT_OUT;
                end
                else
                begin
                    ctl.emit_rd = 1'b1;
                    state_next = htb_pkg::ST_EMIT_STEP;
                end
            end
            htb_pkg::ST_EMIT_STEP:
            begin
                ctl.emit_step = 1'b1;
                state_next = htb_pkg::ST_EMIT_RD;
            end
            htb_pkg::ST_EMIT_OUT:
            begin
                ctl.emit_out = 1'b1;
                if (sts.leaves_done)
                begin
                    ctl.build_done = 1'b1;
                    state_next = htb_pkg::ST_IDLE;
                end
                else
                begin
                    ctl.emit_next = 1'b1;
                    state_next = htb_pkg::ST_EMIT_INIT;
                end
            end
            htb_pkg::ST_DEC_RD:
            begin
                state_next = htb_pkg::ST_DEC_OUT;
            end
            htb_pkg::ST_DEC_OUT:
            begin
                ctl.dec_out = 1'b1;
                state_next = htb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = htb_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == htb_pkg::ST_IDLE) |-> !busy)
        else $error("busy while idle");
    a_dec_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == htb_pkg::ST_DEC_RD) |=> (state_reg == htb_pkg::ST_DEC_OUT))
        else $error("decode sequence broken");
    a_merge_then_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == htb_pkg::ST_MERGE) |=> (state_reg == htb_pkg::ST_SCAN))
        else $error("merge not followed by scan");
`endif
endmodule
`default_nettype wire

@@ rtl/core/htb_dp.sv @@
// Datapath for the tree build codec core: node memories, search and code walk.
`default_nettype none
module htb_dp #(
    parameter int MAX_LEAVES  = htb_pkg::MAX_LEAVES_DEF,
    parameter int WEIGHT_BITS = htb_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire htb_pkg::htb_cmd_t          ctl,
    input  wire logic [htb_pkg::SYM_W-1:0]  symbol,
    input  wire logic [15:0]                weight,
    input  wire logic                       code_bit,
    output htb_pkg::htb_sts_t               sts,
    output logic                            strobe,
    output logic                            kind,
    output logic [htb_pkg::SYM_W-1:0]       out_symbol,
    output logic [htb_pkg::CODE_W-1:0]      code_bits,
    output logic [htb_pkg::LEN_W-1:0]       code_length,
    output logic                            last
);
    localparam int NODES = 2 * MAX_LEAVES - 1;
    localparam int NW    = $clog2(NODES);
    localparam int LW    = $clog2(MAX_LEAVES);
    localparam int CW    = $clog2(MAX_LEAVES + 1);
    localparam int WW    = WEIGHT_BITS + LW + 1;
    localparam int WB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

    // Node memories; has-parent flags are per-node flip-flops.
    logic [WW-1:0]            wt_mem [NODES];
    logic [NW-1:0]            par_mem [NODES];
    logic [NW-1:0]            lft_mem [NODES];
    logic [NW-1:0]            rgt_mem [NODES];
    // Set when the node is the right child of its parent.
    logic                     side_mem [NODES];
    logic [htb_pkg::SYM_W-1:0] sym_mem [MAX_LEAVES];
    logic [NODES-1:0]         hasp_reg;

    logic [CW-1:0] leaf_count_reg;
    logic          tree_ready_reg;
    logic [NW-1:0] walk_reg;
    logic [NW:0]   next_node_reg;
    logic [NW:0]   scan_idx_reg;
    logic          have1_reg, have2_reg;
    logic [WW-1:0] w1_reg, w2_reg;
    logic [NW-1:0] i1_reg, i2_reg;
    logic [LW:0]   leaf_idx_reg;
    logic [NW-1:0] cur_reg;
    logic [NW-1:0] par_rd_reg;
    logic          side_rd_reg;
    logic [htb_pkg::CODE_W-1:0] code_reg;
    logic [htb_pkg::LEN_W-1:0]  len_reg;
    logic [NW-1:0] child_rd_reg;
    logic [htb_pkg::SYM_W-1:0] dsym_reg;

    logic [CW-1:0] cnt_eff;
    logic          store_ok;
    logic [WW-1:0] scan_w;
    logic [NW-1:0] scan_i;
    logic [NW-1:0] total_m1;
    logic [NW-1:0] cnt_idx;

    assign cnt_eff  = tree_ready_reg ? '0 : leaf_count_reg;
    assign store_ok = (cnt_eff < CW'(MAX_LEAVES));
    assign scan_i   = scan_idx_reg[NW-1:0];
    assign total_m1 = NW'({leaf_count_reg, 1'b0} - 2);
    assign cnt_idx  = NW'(cnt_eff);

    // Status toward the controller.
    always_comb
    begin
        sts = '0;
        sts.has_leaves  = store_ok || (cnt_eff != '0);
        sts.scan_end    = (scan_idx_reg + 1'b1 >= next_node_reg);
        sts.merges_done = (next_node_reg >= (NW+1)'({leaf_count_reg, 1'b0} - 1));
        sts.at_root     = !hasp_reg[cur_reg] || (len_reg == 6'd63);
        sts.leaves_done = ((leaf_idx_reg + 1'b1) == (LW+1)'(leaf_count_reg));
        sts.dec_ok      = tree_ready_reg && (leaf_count_reg >= CW'(2));
    end

    // Single synchronous read port for the weight memory during a search.
    always_ff @(posedge clk)
    begin
        scan_w <= wt_mem[scan_i];
    end

    // Leaf count, tree flag, walk node and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= '0;
            tree_ready_reg <= 1'b0;
            walk_reg       <= '0;
            strobe         <= 1'b0;
        end
        else
        begin
            strobe <= 1'b0;
            if (ctl.load)
            begin
                tree_ready_reg <= 1'b0;
                leaf_count_reg <= store_ok ? cnt_eff + 1'b1 : cnt_eff;
            end
            if (ctl.build_done)
            begin
                tree_ready_reg <= 1'b1;
                walk_reg       <= total_m1;
            end
            if (ctl.emit_out)
                strobe <= 1'b1;
            if (ctl.dec_out)
            begin
                if (child_rd_reg < NW'(leaf_count_reg))
                begin
                    strobe   <= 1'b1;
                    walk_reg <= total_m1;
                end
                else
                begin
                    walk_reg <= child_rd_reg;
                end
            end
        end
    end

    // Memories, search and walk registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load && store_ok)
        begin
            sym_mem[cnt_idx[LW-1:0]] <= symbol;
            wt_mem[cnt_idx]  <= WW'(weight[WB-1:0]);
            hasp_reg[cnt_idx] <= 1'b0;
        end
        if (ctl.scan_init)
        begin
            scan_idx_reg <= '0;
            if (ctl.load)
                next_node_reg <= (NW+1)'(store_ok ? cnt_eff + 1'b1 : cnt_eff);
        end
        if (ctl.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (ctl.merge)
        begin
            hasp_reg[i1_reg] <= 1'b1;
            hasp_reg[i2_reg] <= 1'b1;
            par_mem[i1_reg] <= next_node_reg[NW-1:0];
            par_mem[i2_reg] <= next_node_reg[NW-1:0];
            side_mem[i1_reg] <= 1'b0;
            side_mem[i2_reg] <= 1'b1;
            lft_mem[next_node_reg[NW-1:0]] <= i1_reg;
            rgt_mem[next_node_reg[NW-1:0]] <= i2_reg;
            wt_mem[next_node_reg[NW-1:0]]  <= w1_reg + w2_reg;
            hasp_reg[next_node_reg[NW-1:0]] <= 1'b0;
            next_node_reg <= next_node_reg + 1'b1;
        end
        if (ctl.scan_init && ctl.load)
            leaf_idx_reg <= '0;
        if (ctl.emit_init)
        begin
            cur_reg  <= NW'(leaf_idx_reg);
            code_reg <= '0;
            len_reg  <= '0;
        end
        if (ctl.emit_rd)
        begin
            par_rd_reg  <= par_mem[cur_reg];
            side_rd_reg <= side_mem[cur_reg];
        end
        if (ctl.emit_step)
        begin
            if (side_rd_reg)
                code_reg[len_reg] <= 1'b1;
            len_reg <= len_reg + 1'b1;
            cur_reg <= par_rd_reg;
        end
        if (ctl.emit_next)
            leaf_idx_reg <= leaf_idx_reg + 1'b1;
        if (ctl.dec_rd)
            child_rd_reg <= code_bit ? rgt_mem[walk_reg] : lft_mem[walk_reg];
        if (ctl.dec_out)
            dsym_reg <= sym_mem[child_rd_reg[LW-1:0]];
        if (ctl.emit_out)
            dsym_reg <= sym_mem[leaf_idx_reg[LW-1:0]];
    end

    // Search compare in the cycle after the read.
    logic          scan_v_reg;
    logic [NW-1:0] scan_ii_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_v_reg <= 1'b0;
        end
        else
        begin
            scan_v_reg <= ctl.scan_step && !hasp_reg[scan_i];
        end
    end
    always_ff @(posedge clk)
    begin
        scan_ii_reg <= scan_i;
        if (ctl.scan_init)
        begin
            have1_reg <= 1'b0;
            have2_reg <= 1'b0;
        end
        else if (scan_v_reg)
        begin
            if (!have1_reg || scan_w < w1_reg)
            begin
                i2_reg <= i1_reg; w2_reg <= w1_reg; have2_reg <= have1_reg;
                i1_reg <= scan_ii_reg; w1_reg <= scan_w; have1_reg <= 1'b1;
            end
            else if (!have2_reg || scan_w < w2_reg)
            begin
                i2_reg <= scan_ii_reg; w2_reg <= scan_w; have2_reg <= 1'b1;
            end
        end
    end

    // Result registers; the code is collected leaf bit first, so the root bit
    // lands in the most significant valid position.
    logic kind_reg, last_reg;
    logic [htb_pkg::CODE_W-1:0] cb_reg;
    logic [htb_pkg::LEN_W-1:0]  cl_reg;
    always_ff @(posedge clk)
    begin
        if (ctl.emit_out)
        begin
            kind_reg <= 1'b0;
            cb_reg   <= code_reg;
            cl_reg   <= len_reg;
            last_reg <= sts.leaves_done;
        end
        if (ctl.dec_out)
        begin
            kind_reg <= 1'b1;
            cb_reg   <= '0;
            cl_reg   <= '0;
            last_reg <= 1'b0;
        end
    end

    assign kind        = kind_reg;
    assign out_symbol  = dsym_reg;
    assign code_bits   = cb_reg;
    assign code_length = cl_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("results back to back");
    a_ready_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        tree_ready_reg |-> (leaf_count_reg != '0))
        else $error("tree ready with no leaves");
    a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.merge |-> (next_node_reg < (NW+1)'(NODES)))
        else $error("merge beyond node store");
`endif
endmodule
`default_nettype wire

@@ rtl/core/huffman_tree_build_codec_core.sv @@
// Top level of the tree build codec core.
// Takes one command on start while busy is low; a load without the last-leaf mark keeps the core
// idle, and a decode bit passes through the DEC_RD and DEC_OUT states. After the last leaf the build
// runs n-1 minimum searches for n leaves, each reading every node made so far through one weight
// memory port at one node per cycle, and then walks the code of each leaf one level per step.
// Results appear for one cycle on strobe and cannot be stalled.
`default_nettype none
module huffman_tree_build_codec_core #(
    parameter int MAX_LEAVES  = htb_pkg::MAX_LEAVES_DEF,
    parameter int WEIGHT_BITS = htb_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       cmd,
    input  wire logic [htb_pkg::SYM_W-1:0]  symbol,
    input  wire logic [15:0]                weight,
    input  wire logic                       last_leaf,
    input  wire logic                       code_bit,
    output logic                            strobe,
    output logic                            kind,
    output logic [htb_pkg::SYM_W-1:0]       out_symbol,
    output logic [htb_pkg::CODE_W-1:0]      code_bits,
    output logic [htb_pkg::LEN_W-1:0]       code_length,
    output logic                            last
);
    htb_pkg::htb_cmd_t ctl;
    htb_pkg::htb_sts_t sts;

    htb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .last_leaf(last_leaf), .sts(sts), .ctl(ctl), .busy(busy)
    );

    htb_dp #(.MAX_LEAVES(MAX_LEAVES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .symbol(symbol), .weight(weight), .code_bit(code_bit), .sts(sts),
        .strobe(strobe), .kind(kind), .out_symbol(out_symbol),
        .code_bits(code_bits), .code_length(code_length), .last(last)
    );
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the Huffman tree build and decode core.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAF_MAX  = 32;
    localparam int NODE_MAX  = 2 * LEAF_MAX - 1;
    localparam int CYCLE_CAP = 3000000;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;
    localparam logic KIND_CODE  = 1'b0;
    localparam logic KIND_SYM   = 1'b1;

    typedef struct {
        logic        cmd;
        logic [7:0]  sym;
        logic [15:0] wt;
        logic        last_leaf;
        logic        bitv;
        bit          drain_first;
    } cmd_item_t;

    typedef struct {
        logic        kind;
        logic [7:0]  sym;
        logic [62:0] code;
        logic [5:0]  len;
        logic        last;
    } code_out_t;

    logic clk, rst_n, start, busy, cmd, last_leaf, code_bit;
    logic [7:0]  symbol;
    logic [15:0] weight;
    logic strobe, kind, last;
    logic [7:0]  out_symbol;
    logic [62:0] code_bits;
    logic [5:0]  code_length;

    huffman_tree_build_codec_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .symbol(symbol), .weight(weight), .last_leaf(last_leaf), .code_bit(code_bit),
        .strobe(strobe), .kind(kind), .out_symbol(out_symbol), .code_bits(code_bits),
        .code_length(code_length), .last(last)
    );

    // 4 ns clock.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    cmd_item_t pending_cmds[$];
    code_out_t expected_codes[$];
    cmd_item_t cur_cmd;
    int errors = 0;
    int accepted = 0;
    int total_cmds = 0;
    int quiet_cycles = 0;
    longint cycles = 0;

    // Shadow copy of the tree.
    longint tree_wt[NODE_MAX];
    int tree_par[NODE_MAX], tree_lft[NODE_MAX], tree_rgt[NODE_MAX];
    bit tree_linked[NODE_MAX];
    logic [7:0] leaf_sym[LEAF_MAX];
    int n_leaves = 0, walk_pos = 0;
    bit tree_valid = 0;

    // Merge the two lightest free nodes repeatedly, then emit one code per leaf.
    function automatic void build_codes();
        int n, total, a, b, c, p, len;
        longint w1, w2;
        bit h1, h2;
        logic [63:0] code;
        code_out_t r;
        n = n_leaves;
        total = 2 * n - 1;
        for (int i = n; i < total; i++)
        begin
            h1 = 0; h2 = 0; w1 = 0; w2 = 0; a = 0; b = 0;
            for (int j = 0; j < i; j++)
            begin
                if (tree_linked[j])
                    continue;
                if (!h1 || tree_wt[j] < w1)
                begin
                    b = a; w2 = w1; h2 = h1;
                    a = j; w1 = tree_wt[j]; h1 = 1;
                end
                else if (!h2 || tree_wt[j] < w2)
                begin
                    b = j; w2 = tree_wt[j]; h2 = 1;
                end
            end
            tree_par[a] = i; tree_linked[a] = 1;
            tree_par[b] = i; tree_linked[b] = 1;
            tree_lft[i] = a;
            tree_rgt[i] = b;
            tree_wt[i] = tree_wt[a] + tree_wt[b];
            tree_linked[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            code = '0; len = 0; c = i;
            while (tree_linked[c] && len < 63)
            begin
                p = tree_par[c];
                if (tree_rgt[p] == c && tree_lft[p] != c)
                    code[len] = 1'b1;
                len++;
                c = p;
            end
            r.kind = KIND_CODE;
            r.sym = leaf_sym[i];
            r.code = code[62:0];
            r.len = len[5:0];
            r.last = (i + 1 == n);
            expected_codes.push_back(r);
        end
        walk_pos = total - 1;
        tree_valid = 1;
    endfunction

    // Update the shadow state for one accepted command.
    function automatic void predict_codes(cmd_item_t it);
        code_out_t r;
        if (it.cmd == CMD_LOAD)
        begin
            if (tree_valid)
            begin
                tree_valid = 0;
                n_leaves = 0;
            end
            if (n_leaves < LEAF_MAX)
            begin
                leaf_sym[n_leaves] = it.sym;
                tree_wt[n_leaves] = it.wt;
                tree_linked[n_leaves] = 0;
                tree_par[n_leaves] = 0;
                n_leaves++;
            end
            if (it.last_leaf && n_leaves > 0)
                build_codes();
        end
        else if (tree_valid && n_leaves >= 2)
        begin
            walk_pos = it.bitv ? tree_rgt[walk_pos] : tree_lft[walk_pos];
            if (walk_pos < n_leaves)
            begin
                r.kind = KIND_SYM;
                r.sym = leaf_sym[walk_pos];
                r.code = '0;
                r.len = '0;
                r.last = 1'b0;
                expected_codes.push_back(r);
                walk_pos = 2 * n_leaves - 2;
            end
        end
    endfunction

    function automatic void add_cmd(logic c, logic [7:0] s, logic [15:0] w, logic ll,
                                    logic b, bit drain);
        cmd_item_t it;
        it.cmd = c; it.sym = s; it.wt = w; it.last_leaf = ll; it.bitv = b;
        it.drain_first = drain;
        pending_cmds.push_back(it);
    endfunction

    // One leaf set with random content, followed by a run of decode bits.
    function automatic void add_set(int n, int decodes);
        logic [15:0] w;
        for (int i = 0; i < n; i++)
        begin
            w = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            add_cmd(CMD_LOAD, 8'($urandom), w, i == n - 1, 1'($urandom), 0);
        end
        for (int i = 0; i < decodes; i++)
            add_cmd(CMD_DECODE, 8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), 0);
    endfunction

    // Idle pattern: none, then 81 in 100, then none, then 28 in 100.
    function automatic bit sender_idle();
        int phase;
        phase = (accepted * 4) / (total_cmds + 1);
        if (phase == 1)
            return $urandom_range(0, 99) < 81;
        if (phase == 3)
            return $urandom_range(0, 99) < 28;
        return 0;
    endfunction

    // Driver: presents commands from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= CMD_LOAD; symbol <= '0; weight <= '0; last_leaf <= 1'b0; code_bit <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_codes(cur_cmd);
                accepted++;
            end
            if (!start || !busy)
            begin
                if (pending_cmds.size() > 0 && !sender_idle() &&
                    (!pending_cmds[0].drain_first || quiet_cycles >= 100))
                begin
                    cur_cmd = pending_cmds.pop_front();
                    start <= 1'b1;
                    cmd <= cur_cmd.cmd;
                    symbol <= cur_cmd.sym;
                    weight <= cur_cmd.wt;
                    last_leaf <= cur_cmd.last_leaf;
                    code_bit <= cur_cmd.bitv;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        cycles++;
        quiet_cycles = (expected_codes.size() == 0 && !busy) ? quiet_cycles + 1 : 0;
        if (rst_n && strobe)
        begin
            if (expected_codes.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d sym=%0h", $time, kind, out_symbol);
                errors++;
            end
            else
            begin
                code_out_t e;
                e = expected_codes.pop_front();
                if (e.kind !== kind || e.sym !== out_symbol || e.code !== code_bits ||
                    e.len !== code_length || e.last !== last)
                begin
                    $display("%0t: expected kind=%0d sym=%0h code=%0h len=%0d last=%0d",
                             $time, e.kind, e.sym, e.code, e.len, e.last);
                    $display("%0t: actual   kind=%0d sym=%0h code=%0h len=%0d last=%0d",
                             $time, kind, out_symbol, code_bits, code_length, last);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_CAP)
        begin
            $display("huffman_tree_build_codec_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        // Directed: decode with no tree, single leaf, extremes, ties.
        add_cmd(CMD_DECODE, 8'h00, 16'h0000, 1'b0, 1'b0, 0);
        add_cmd(CMD_DECODE, 8'hff, 16'hffff, 1'b1, 1'b1, 0);
        add_cmd(CMD_LOAD, 8'hff, 16'hffff, 1'b1, 1'b1, 0);
        add_cmd(CMD_DECODE, 8'h00, 16'h0000, 1'b0, 1'b0, 0);
        add_cmd(CMD_DECODE, 8'h00, 16'h0000, 1'b0, 1'b1, 0);
        add_cmd(CMD_LOAD, 8'h00, 16'h0000, 1'b0, 1'b0, 0);
        add_cmd(CMD_LOAD, 8'hff, 16'hffff, 1'b1, 1'b0, 0);
        add_cmd(CMD_DECODE, 8'h00, 16'h0000, 1'b0, 1'b0, 0);
        add_cmd(CMD_DECODE, 8'h00, 16'h0000, 1'b0, 1'b1, 0);
        for (int i = 0; i < 4; i++)
            add_cmd(CMD_LOAD, 8'(8'h10 + i), 16'd5, i == 3, 1'b0, 0);
        for (int i = 0; i < 6; i++)
            add_cmd(CMD_DECODE, 8'h00, 16'h0000, 1'b0, 1'(i), 0);
        // Random sets: mostly small, a few full and overflowing ones.
        while (pending_cmds.size() < 255)
        begin
            case ($urandom_range(0, 9))
                0: n = LEAF_MAX + $urandom_range(0, 2);
                1: n = 1;
                default: n = $urandom_range(2, 8);
            endcase
            add_set(n, $urandom_range(0, 12));
            if ($urandom_range(0, 5) == 0)
                add_cmd(CMD_LOAD, 8'($urandom), 16'($urandom), 1'b0, 1'($urandom), 0);
            if ($urandom_range(0, 7) == 0)
                pending_cmds[$].drain_first = 1;
        end
        pending_cmds[150].drain_first = 1;
        total_cmds = pending_cmds.size();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_cmds.size() == 0);
        @(posedge clk);
        while (start || busy || expected_codes.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_codes.size() == 0)
            $display("huffman_tree_build_codec_core: match");
        else
            $display("huffman_tree_build_codec_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/htb_pkg.sv
rtl/core/htb_ctrl.sv
rtl/core/htb_dp.sv
rtl/core/huffman_tree_build_codec_core.sv
bench/tb.sv
